@@ rtl/lfid_pkg.sv @@
// Shared types and constants for the lowest-free ID allocator.
// Holds the transfer structs, status and function codes, and map word sizing.
// No dependencies.
package lfid_pkg;

  localparam int NUM_SLOTS_DEF = 256;
  localparam int WORD_W        = 16;
  localparam int WORD_LG       = 4;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] slot;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] id;
    logic [8:0] in_use_count;
    logic [8:0] end_mark;
  } out_t;

endpackage

@@ rtl/lowest_free_id_allocator.sv @@
// Lowest-free ID allocator: top level with the word-organized occupancy map.
// Depends on lfid_pkg.
//
// Hands out the lowest free ID of NUM_SLOTS and takes IDs back, one request
// at a time. The occupancy map sits in a simple dual-port memory of 16-bit
// words with one registered read per cycle, and that read port sets the
// rate: an allocate sets the bit of the lowest free ID in S_AMOD and scans
// upward one word per read in S_ASCAN to the next free ID; a free clears
// the slot's bit in S_FMOD, reads the end-mark word in S_FRD and pulls the
// end mark down word by word in S_FSCAN; a full allocate or a free of a slot
// out of range goes to S_DONE. A result waits in the output register while
// the next request is taken. Each map word has a valid bit cleared by reset,
// so the map reads as all free right after reset with no clearing pass.
module lowest_free_id_allocator
  import lfid_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PTR_W     = $clog2(NUM_WORDS * WORD_W + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AMOD  = 7'b0000010,
    S_ASCAN = 7'b0000100,
    S_FMOD  = 7'b0001000,
    S_FRD   = 7'b0010000,
    S_FSCAN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [PTR_W-1:0]   ff_q, ff_d, ep_q, ep_d, cnt_q, cnt_d, slot_q, slot_d;
  logic [WA_W-1:0]    scan_w_q, scan_w_d;
  logic [WORD_LG-1:0] lim_q, lim_d;
  status_e            res_st_q, res_st_d;
  logic [7:0]         res_id_q, res_id_d;

  logic               out_valid_q;
  out_t               out_q;
  logic               out_load;

  // map memory
  logic [WORD_W-1:0]  mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]  rd_data_q;
  logic               rd_vld_q;
  logic               rd_en, wr_en;
  logic [WA_W-1:0]    rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  word;

  // search helpers
  logic [WORD_W-1:0]  low_mask, up_word, scan_src, lim_mask, hi_src;
  logic [WORD_LG-1:0] bit_sel, lz_pos, hs_pos;
  logic               lz_found, hs_found;
  logic [PTR_W:0]     cand;
  logic [PTR_W-1:0]   ff_new, e_ptr;
  logic               slot_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // a word never written reads as all free
  assign word = rd_vld_q ? rd_data_q : '0;

  assign bit_sel = (state_q == S_AMOD) ? ff_q[WORD_LG-1:0] : slot_q[WORD_LG-1:0];
  assign up_word = word | (WORD_W'(1) << bit_sel);
  assign e_ptr   = ep_q - PTR_W'(1);
  assign slot_ok = (int'(in_data_i.slot) < NUM_SLOTS);

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      low_mask[i] = (WORD_LG'(i) <= bit_sel);
      lim_mask[i] = (WORD_LG'(i) <= lim_q);
    end
  end

  // upward scan: skip bits at or below the new allocation in the first word
  assign scan_src = (state_q == S_AMOD) ? (up_word | low_mask) : word;
  assign hi_src   = word & lim_mask;

  always_comb begin
    lz_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_src[i]) begin
        lz_pos = WORD_LG'(i);
      end
    end
    hs_pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (hi_src[i]) begin
        hs_pos = WORD_LG'(i);
      end
    end
  end

  assign lz_found = ~&scan_src;
  assign hs_found = |hi_src;
  assign cand     = (PTR_W + 1)'({scan_w_q, lz_pos});
  assign ff_new   = (cand > (PTR_W + 1)'(NUM_SLOTS)) ? PTR_W'(NUM_SLOTS) : cand[PTR_W-1:0];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    ff_d     = ff_q;
    ep_d     = ep_q;
    cnt_d    = cnt_q;
    slot_d   = slot_q;
    scan_w_d = scan_w_q;
    lim_d    = lim_q;
    res_st_d = res_st_q;
    res_id_d = res_id_q;
    rd_en    = 1'b0;
    rd_addr  = scan_w_q;
    wr_en    = 1'b0;
    wr_addr  = scan_w_q;
    wr_data  = up_word;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_id_d = '0;
          if (in_data_i.func == FUNC_ALLOC) begin
            if (ff_q >= PTR_W'(NUM_SLOTS)) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = ff_q[WORD_LG +: WA_W];
              scan_w_d = ff_q[WORD_LG +: WA_W];
              state_d  = S_AMOD;
            end
          end else begin
            if (!slot_ok) begin
              res_st_d = ST_NOT_USED;
              state_d  = S_DONE;
            end else begin
              slot_d   = PTR_W'(in_data_i.slot);
              rd_en    = 1'b1;
              rd_addr  = WA_W'(in_data_i.slot >> WORD_LG);
              scan_w_d = WA_W'(in_data_i.slot >> WORD_LG);
              state_d  = S_FMOD;
            end
          end
        end
      end
      S_AMOD, S_ASCAN: begin
        if (state_q == S_AMOD) begin
          wr_en    = 1'b1;
          wr_data  = up_word;
          res_st_d = ST_OK;
          res_id_d = 8'(ff_q);
          cnt_d    = cnt_q + PTR_W'(1);
        end
        if (lz_found || scan_w_q == WA_W'(NUM_WORDS - 1)) begin
          // past the last word means no free slot is left
          ff_d    = lz_found ? ff_new : PTR_W'(NUM_SLOTS);
          ep_d    = ((lz_found ? ff_new : PTR_W'(NUM_SLOTS)) > ep_q) ?
                    (lz_found ? ff_new : PTR_W'(NUM_SLOTS)) : ep_q;
          state_d = S_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = scan_w_q + WA_W'(1);
          scan_w_d = scan_w_q + WA_W'(1);
          state_d  = S_ASCAN;
        end
      end
      S_FMOD: begin
        if (!word[bit_sel]) begin
          res_st_d = ST_NOT_USED;
          state_d  = S_DONE;
        end else begin
          wr_en    = 1'b1;
          wr_data  = word & ~(WORD_W'(1) << bit_sel);
          res_st_d = ST_OK;
          if (ff_q > slot_q) begin
            ff_d = slot_q;
          end
          if (cnt_q != '0) begin
            cnt_d = cnt_q - PTR_W'(1);
          end
          // read the end-mark word only after the write has landed
          state_d = (ep_q == '0) ? S_DONE : S_FRD;
        end
      end
      S_FRD: begin
        rd_en    = 1'b1;
        rd_addr  = e_ptr[WORD_LG +: WA_W];
        scan_w_d = e_ptr[WORD_LG +: WA_W];
        lim_d    = e_ptr[WORD_LG-1:0];
        state_d  = S_FSCAN;
      end
      S_FSCAN: begin
        if (hs_found) begin
          ep_d    = PTR_W'({scan_w_q, hs_pos}) + PTR_W'(1);
          state_d = S_DONE;
        end else begin
          ep_d = PTR_W'({scan_w_q, {WORD_LG{1'b0}}});
          if (scan_w_q == '0) begin
            state_d = S_DONE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = scan_w_q - WA_W'(1);
            scan_w_d = scan_w_q - WA_W'(1);
            lim_d    = '1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ff_q        <= '0;
      ep_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ff_q    <= ff_d;
      ep_q    <= ep_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    scan_w_q <= scan_w_d;
    lim_q    <= lim_d;
    res_st_q <= res_st_d;
    res_id_q <= res_id_d;
    if (out_load) begin
      out_q.status       <= res_st_q;
      out_q.id           <= res_id_q;
      out_q.in_use_count <= 9'(cnt_q);
      out_q.end_mark     <= 9'(ep_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/lfid_checker.sv @@
// Port-level checks for the lowest-free ID allocator, bound to the top level.
// Depends on lfid_pkg and lowest_free_id_allocator.
module lfid_checker
  import lfid_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // one request at a time: a transfer in always makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a request was still at work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |->
      (out_data_o.id == 8'd0 && out_data_o.in_use_count == 9'(NUM_SLOTS)))
    else $error("full status without every slot in use");

  a_count_below_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((NUM_SLOTS > 256) ||
                     (out_data_o.in_use_count <= out_data_o.end_mark)))
    else $error("more IDs in use than the end mark covers");

endmodule

bind lowest_free_id_allocator lfid_checker #(.NUM_SLOTS(NUM_SLOTS)) u_lfid_checker (.*);

@@ tb/lowest_free_id_allocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for lowest_free_id_allocator: directed table, then fill/drain/churn runs.
// Predicts every grant and release from its own copy of the occupancy map.
// Depends on lfid_pkg and the allocator RTL.
module lowest_free_id_allocator_tb
  import lfid_pkg::*;
;

  localparam int SLOTS       = NUM_SLOTS_DEF;
  localparam int ITEMS       = 1050;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_CHURN
  } phase_e;

  typedef struct {
    in_t  req;
    bit   known;
    out_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // shadow allocator state
  logic [SLOTS-1:0] occ_map;
  int unsigned      first_free;
  int unsigned      end_ptr;
  int unsigned      n_used;

  out_t grant_q[$];
  int   n_bad    = 0;
  int   n_sent   = 0;
  bit   idle_off = 1'b0;
  bit   hold_req = 1'b0;

  lowest_free_id_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Advance the shadow map by one request and return the result it must produce.
  function automatic out_t grant_result(in_t req);
    out_t        res;
    int unsigned got;
    res = '0;
    if (req.func == FUNC_ALLOC) begin
      if (first_free >= SLOTS) begin
        res.status = ST_FULL;
      end else begin
        got = first_free;
        occ_map[got] = 1'b1;
        first_free++;
        while (first_free < SLOTS && occ_map[first_free]) first_free++;
        if (end_ptr < first_free) end_ptr = first_free;
        n_used++;
        res.status = ST_OK;
        res.id     = got[7:0];
      end
    end else if (!occ_map[req.slot]) begin
      res.status = ST_NOT_USED;
    end else begin
      occ_map[req.slot] = 1'b0;
      if (first_free > req.slot) first_free = req.slot;
      // pull the end mark down over trailing free slots
      while (end_ptr > 0 && !occ_map[end_ptr-1]) end_ptr--;
      if (n_used > 0) n_used--;
      res.status = ST_OK;
    end
    res.in_use_count = n_used[8:0];
    res.end_mark     = end_ptr[8:0];
    return res;
  endfunction

  function automatic in_t mk_req(func_e f, logic [7:0] s);
    in_t r;
    r.func = f;
    r.slot = s;
    return r;
  endfunction

  function automatic out_t mk_res(status_e st, int idv, int used, int em);
    out_t r;
    r.status       = st;
    r.id           = idv[7:0];
    r.in_use_count = used[8:0];
    r.end_mark     = em[8:0];
    return r;
  endfunction

  // Random slot currently in use; any slot if the map is empty.
  function automatic logic [7:0] pick_used();
    logic [7:0] pool[$];
    for (int s = 0; s < SLOTS; s++) if (occ_map[s]) pool.push_back(s[7:0]);
    if (pool.size() == 0) return 8'($urandom);
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic flag_bad(string what, out_t want, out_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("mismatch, %s: expected st=%0d id=%0d used=%0d end=%0d", what,
               want.status, want.id, want.in_use_count, want.end_mark);
      $display("                got st=%0d id=%0d used=%0d end=%0d",
               got.status, got.id, got.in_use_count, got.end_mark);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        flag_bad("result with nothing pending", '0, out_data);
      end else if (out_data.status !== grant_q[0].status ||
                   out_data.id !== grant_q[0].id ||
                   out_data.in_use_count !== grant_q[0].in_use_count ||
                   out_data.end_mark !== grant_q[0].end_mark) begin
        flag_bad("field", grant_q[0], out_data);
        void'(grant_q.pop_front());
      end else begin
        void'(grant_q.pop_front());
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rx_side
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 6) == 0) begin
        left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request, recording its expected result; returns at the falling edge after transfer.
  task automatic offer(in_t req, bit known, out_t want);
    out_t pred;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    pred = grant_result(req);
    grant_q.push_back(known ? want : pred);
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (n_sent > ITEMS - 120) idle_off = 1'b1;
  endtask

  // Hold the sender until every pending result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (grant_q.size() != 0) @(negedge clk);
  endtask

  initial begin : stim
    dir_row_t dir_rows[$];
    phase_e   phase;
    int       pick;
    int       runlen;
    bit       first_hold;

    occ_map    = '0;
    first_free = 0;
    end_ptr    = 0;
    n_used     = 0;
    first_hold = 1'b1;

    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'h00), 1, mk_res(ST_OK, 0, 1, 1)});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h00), 1, mk_res(ST_OK, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h00), 1, mk_res(ST_NOT_USED, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'hFF), 1, mk_res(ST_NOT_USED, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'hAA), 1, mk_res(ST_NOT_USED, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'hFF), 1, mk_res(ST_OK, 0, 1, 1)});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'h55), 1, mk_res(ST_OK, 1, 2, 2)});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'h00), 1, mk_res(ST_OK, 2, 3, 3)});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'hAA), 1, mk_res(ST_OK, 3, 4, 4)});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h01), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h03), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'h00), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'h00), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h02), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h55), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h02), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_ALLOC, 8'h7F), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h03), 0, '0});
    dir_rows.push_back('{mk_req(FUNC_FREE, 8'h00), 0, '0});

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
    wait_drained();

    phase = PH_FILL;
    while (n_sent < ITEMS) begin
      idle_off = ($urandom_range(0, 3) == 0) || (n_sent > ITEMS - 120);
      case (phase)
        PH_FILL: begin
          while (first_free < SLOTS && n_sent < ITEMS) begin
            if ($urandom_range(0, 9) == 0) offer(mk_req(FUNC_FREE, pick_used()), 0, '0);
            else offer(mk_req(FUNC_ALLOC, 8'($urandom)), 0, '0);
          end
          // push past full
          repeat ($urandom_range(1, 3)) offer(mk_req(FUNC_ALLOC, 8'($urandom)), 0, '0);
        end
        PH_DRAIN: begin
          if (first_hold) begin
            first_hold = 1'b0;
            hold_req   = 1'b1;
          end
          while (n_used > 0 && n_sent < ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) offer(mk_req(FUNC_ALLOC, 8'($urandom)), 0, '0);
            else if (pick < 3) offer(mk_req(FUNC_FREE, 8'($urandom)), 0, '0);
            else offer(mk_req(FUNC_FREE, pick_used()), 0, '0);
          end
          offer(mk_req(FUNC_FREE, 8'($urandom)), 0, '0);
        end
        default: begin
          runlen = $urandom_range(40, 120);
          if (runlen > ITEMS - n_sent) runlen = ITEMS - n_sent;
          repeat (runlen) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) offer(mk_req(FUNC_ALLOC, 8'($urandom)), 0, '0);
            else if (pick < 9) offer(mk_req(FUNC_FREE, pick_used()), 0, '0);
            else offer(mk_req(FUNC_FREE, 8'($urandom)), 0, '0);
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) wait_drained();
      phase = first_hold ? PH_DRAIN : phase_e'($urandom_range(0, 2));
    end

    idle_off = 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && grant_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
